@@ design/rfpte_pkg.sv @@
// Shared types and constants for the pulse-train switch encoder.
`timescale 1ns / 1ps
package rfpte_pkg;

  localparam int DATA_BITS  = 32;
  localparam int ID_W       = 26;
  localparam int UNIT_W     = 4;
  localparam int DUR_W      = 18;
  localparam int CNT_W      = 3;
  localparam int BASE_W     = 12;
  localparam int LONG_W     = 4;
  localparam int FOOT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int SYM_IDX_W  = 6;
  localparam int START_FACTOR = 9;

  localparam logic [SYM_IDX_W-1:0] END_SYMBOL = SYM_IDX_W'(DATA_BITS + 1);

  localparam logic [BASE_W-1:0] BASE_PULSE_RST    = BASE_W'(315);
  localparam logic [LONG_W-1:0] LONG_FACTOR_RST   = LONG_W'(5);
  localparam logic [FOOT_W-1:0] FOOTER_FACTOR_RST = FOOT_W'(34);

  localparam logic [CNT_W-1:0] PC_NONE = CNT_W'(0);
  localparam logic [CNT_W-1:0] PC_PAIR = CNT_W'(2);
  localparam logic [CNT_W-1:0] PC_QUAD = CNT_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_PULSE    = 2'd0,
    REG_LONG_FACTOR   = 2'd1,
    REG_FOOTER_FACTOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_pulse;
    logic [LONG_W-1:0] long_factor;
    logic [FOOT_W-1:0] footer_factor;
  } cfg_t;

  typedef struct packed {
    logic                 bad;
    logic [DATA_BITS-1:0] frame;
  } cmd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [DUR_W-1:0] dur_a;
    logic [DUR_W-1:0] dur_b;
    logic [DUR_W-1:0] dur_c;
    logic [DUR_W-1:0] dur_d;
    logic [CNT_W-1:0] pulse_count;
    logic             last_symbol;
    logic             bad_command;
  } sym_t;

endpackage

@@ design/rfpte_if.sv @@
// Handshake interfaces for the command and symbol channels.
`timescale 1ns / 1ps
interface rfpte_cmd_if;
  logic                     valid;
  logic                     ready;
  logic [rfpte_pkg::ID_W-1:0]   device_id;
  logic [rfpte_pkg::UNIT_W-1:0] unit_code;
  logic                     group_all;
  logic                     switch_on;

  modport source (output valid, device_id, unit_code, group_all, switch_on, input ready);
  modport sink   (input valid, device_id, unit_code, group_all, switch_on, output ready);
endinterface

interface rfpte_sym_if;
  logic                        valid;
  logic                        ready;
  logic [rfpte_pkg::DUR_W-1:0] dur_a;
  logic [rfpte_pkg::DUR_W-1:0] dur_b;
  logic [rfpte_pkg::DUR_W-1:0] dur_c;
  logic [rfpte_pkg::DUR_W-1:0] dur_d;
  logic [rfpte_pkg::CNT_W-1:0] pulse_count;
  logic                        last_symbol;
  logic                        bad_command;

  modport source (output valid, dur_a, dur_b, dur_c, dur_d, pulse_count, last_symbol,
                  bad_command, input ready);
  modport sink   (input valid, dur_a, dur_b, dur_c, dur_d, pulse_count, last_symbol,
                  bad_command, output ready);
endinterface

@@ design/rfpte_front.sv @@
// Command intake: checks the id and packs the 32-bit frame.
`timescale 1ns / 1ps
module rfpte_front (
  input  logic                  clk,
  input  logic                  rst,
  rfpte_cmd_if.sink             cmd,
  input  rfpte_pkg::q_status_t  q_stat,
  output logic                  push,
  output rfpte_pkg::cmd_entry_t entry
);
  import rfpte_pkg::*;

  logic       held;
  cmd_entry_t held_entry;
  logic       take;

  assign push      = held && !q_stat.full;
  assign cmd.ready = !held || !q_stat.full;
  assign take      = cmd.valid && cmd.ready;
  assign entry     = held_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_entry.bad   <= (cmd.device_id == '0);
      held_entry.frame <= {cmd.device_id, cmd.group_all, cmd.switch_on, cmd.unit_code};
    end
  end

endmodule

@@ design/rfpte_queue.sv @@
// Two-entry queue of classified commands between intake and symbol generator.
`timescale 1ns / 1ps
module rfpte_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rfpte_pkg::cmd_entry_t entry_in,
  input  logic                  pop,
  output rfpte_pkg::cmd_entry_t entry_out,
  output rfpte_pkg::q_status_t  q_stat
);
  import rfpte_pkg::*;

  cmd_entry_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign q_stat.full  = (fill == 2'd2);
  assign q_stat.empty = (fill == 2'd0);
  assign entry_out    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

endmodule

@@ design/rfpte_back.sv @@
// Symbol generator: walks one frame out as start, 32 data and end symbols, or emits one error word for a bad entry.
`timescale 1ns / 1ps
module rfpte_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rfpte_pkg::cfg_t       cfg,
  input  rfpte_pkg::cmd_entry_t entry,
  input  rfpte_pkg::q_status_t  q_stat,
  output logic                  pop,
  rfpte_sym_if.source           sym
);
  import rfpte_pkg::*;

  logic                 busy;
  logic [SYM_IDX_W-1:0] sym_idx;
  logic [DATA_BITS-1:0] frame;
  logic                 out_valid;
  sym_t                 out_word;

  logic                 busy_next;
  logic [SYM_IDX_W-1:0] sym_idx_next;
  logic [DATA_BITS-1:0] frame_next;
  logic                 out_valid_next;
  sym_t                 out_word_next;
  logic                 load;

  logic [DUR_W-1:0] short_dur;
  logic [DUR_W-1:0] start_dur;
  logic [DUR_W-1:0] long_dur;
  logic [DUR_W-1:0] footer_dur;

  // products are registered from cfg; the user must let writes land only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    short_dur  <= DUR_W'(cfg.base_pulse);
    start_dur  <= DUR_W'(START_FACTOR) * DUR_W'(cfg.base_pulse);
    long_dur   <= DUR_W'(cfg.long_factor) * DUR_W'(cfg.base_pulse);
    footer_dur <= DUR_W'(cfg.footer_factor) * DUR_W'(cfg.base_pulse);
  end

  assign load = !out_valid || sym.ready;
  assign pop  = load && !busy && !q_stat.empty;

  always_comb begin
    busy_next      = busy;
    sym_idx_next   = sym_idx;
    frame_next     = frame;
    out_valid_next = out_valid;
    out_word_next  = out_word;
    if (load) begin
      if (busy) begin
        out_valid_next = 1'b1;
        if (sym_idx == END_SYMBOL) begin
          out_word_next = '{dur_a: short_dur, dur_b: footer_dur, dur_c: '0, dur_d: '0,
                            pulse_count: PC_PAIR, last_symbol: 1'b1, bad_command: 1'b0};
          busy_next     = 1'b0;
        end else begin
          if (frame[DATA_BITS-1]) begin
            out_word_next = '{dur_a: short_dur, dur_b: long_dur, dur_c: short_dur,
                              dur_d: short_dur, pulse_count: PC_QUAD,
                              last_symbol: 1'b0, bad_command: 1'b0};
          end else begin
            out_word_next = '{dur_a: short_dur, dur_b: short_dur, dur_c: short_dur,
                              dur_d: long_dur, pulse_count: PC_QUAD,
                              last_symbol: 1'b0, bad_command: 1'b0};
          end
          frame_next   = frame << 1;
          sym_idx_next = sym_idx + SYM_IDX_W'(1);
        end
      end else if (!q_stat.empty) begin
        out_valid_next = 1'b1;
        if (entry.bad) begin
          out_word_next = '{dur_a: '0, dur_b: '0, dur_c: '0, dur_d: '0,
                            pulse_count: PC_NONE, last_symbol: 1'b1, bad_command: 1'b1};
        end else begin
          out_word_next = '{dur_a: short_dur, dur_b: start_dur, dur_c: '0, dur_d: '0,
                            pulse_count: PC_PAIR, last_symbol: 1'b0, bad_command: 1'b0};
          busy_next     = 1'b1;
          frame_next    = entry.frame;
          sym_idx_next  = SYM_IDX_W'(1);
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sym_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      sym_idx   <= sym_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    frame    <= frame_next;
    out_word <= out_word_next;
  end

  assign sym.valid       = out_valid;
  assign sym.dur_a       = out_word.dur_a;
  assign sym.dur_b       = out_word.dur_b;
  assign sym.dur_c       = out_word.dur_c;
  assign sym.dur_d       = out_word.dur_d;
  assign sym.pulse_count = out_word.pulse_count;
  assign sym.last_symbol = out_word.last_symbol;
  assign sym.bad_command = out_word.bad_command;

endmodule

@@ design/rf_switch_pulse_train_encoder.sv @@
// A command passes the intake holding register and the queue before its first symbol word
// is registered. Throughput: 34 words per command, one per cycle unless sym.ready stalls,
// set by the symbol generator's counter; a zero-id command yields one error word. Commands
// queue two deep. Reset: synchronous; timing registers return to T=315, L=5, F=34, queue
// empties and the output register goes invalid.
`timescale 1ns / 1ps
module rf_switch_pulse_train_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  rfpte_cmd_if.sink                            cmd,
  rfpte_sym_if.source                          sym,
  input  logic                                 cfg_write,
  input  logic [rfpte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfpte_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rfpte_pkg::*;

  cfg_t       cfg;
  cmd_entry_t front_entry;
  cmd_entry_t q_entry;
  q_status_t  q_stat;
  logic       push;
  logic       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_pulse    <= BASE_PULSE_RST;
      cfg.long_factor   <= LONG_FACTOR_RST;
      cfg.footer_factor <= FOOTER_FACTOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_PULSE:    cfg.base_pulse    <= cfg_data[BASE_W-1:0];
        REG_LONG_FACTOR:   cfg.long_factor   <= cfg_data[LONG_W-1:0];
        REG_FOOTER_FACTOR: cfg.footer_factor <= cfg_data[FOOT_W-1:0];
        default: ;
      endcase
    end
  end

  rfpte_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_stat (q_stat),
    .push   (push),
    .entry  (front_entry)
  );

  rfpte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (front_entry),
    .pop       (pop),
    .entry_out (q_entry),
    .q_stat    (q_stat)
  );

  rfpte_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .entry  (q_entry),
    .q_stat (q_stat),
    .pop    (pop),
    .sym    (sym)
  );

  // drop nothing: never write a full queue or read an empty one
  assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full || pop)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("queue read while empty");

  assert property (@(posedge clk) disable iff (rst)
                   sym.valid && sym.bad_command |-> sym.last_symbol && sym.pulse_count == PC_NONE)
    else $error("error word malformed");

  // a data word is always followed by another data word or the end word
  assert property (@(posedge clk) disable iff (rst)
                   sym.valid && sym.ready && sym.pulse_count == PC_QUAD
                   |=> sym.valid && !sym.bad_command)
    else $error("frame broken after data word");

  assert property (@(posedge clk) $past(rst) |-> !sym.valid)
    else $error("output valid straight after reset");

endmodule
